/* src/tiled_background_pixel_render_macros.svh */
`ifndef TILED_BACKGROUND_PIXEL_RENDER_MACROS_SVH
`define TILED_BACKGROUND_PIXEL_RENDER_MACROS_SVH

// same-cycle implication
`define TBPR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TBPR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/tbpr_pkg.sv */
`timescale 1ns / 1ps

package tbpr_pkg;

    localparam int VIDEO_WORDS     = 32768;
    localparam int VIDEO_AW        = $clog2(VIDEO_WORDS);
    localparam int PALETTE_ENTRIES = 256;
    localparam int PAL_AW          = $clog2(PALETTE_ENTRIES);

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 9;

    localparam logic [CFG_IDX_W-1:0] CFG_CHAR_BLOCK   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_BLOCK = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_SIZE     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COLOUR_DEPTH = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SCROLL_X     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SCROLL_Y     = 3'd5;

    localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

    typedef enum logic [1:0] {
        OP_VRAM_WR = 2'd0,
        OP_PAL_WR  = 2'd1,
        OP_RENDER  = 2'd2
    } opcode_t;

endpackage

/* src/tiled_background_pixel_render.sv */
`timescale 1ns / 1ps
// Renders one pixel of a scrolled, wrapping text-mode tile background. Opcode 0 writes a
// video memory halfword and opcode 1 a palette entry; neither gives a result nor leaves
// the sequencer busy. Opcode 2 renders the pixel at (pixel_x, pixel_y) and gives one
// result (colour, opaque); in_stall is high while the sequencer steps through S_MAP,
// S_TILE, S_FETCH, S_PAL and S_DONE, so render items do not overlap, and longer while
// an earlier result waits in the output register under out_stall. The wait is set by
// three dependent reads through the single read port of video memory (map entry, then
// tile byte) and of the palette; video memory has a registered address and registered
// read data, the palette registered read data. A finished result waits in the output
// register while the next item is accepted. Configuration writes are always ready and
// must only be issued while the block is idle. Memory contents are undefined until written.

`include "tiled_background_pixel_render_macros.svh"

module tiled_background_pixel_render
    import tbpr_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,

    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [1:0]            opcode,
    input  logic [14:0]           address,
    input  logic [15:0]           write_data,
    input  logic [7:0]            pixel_x,
    input  logic [7:0]            pixel_y,

    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [31:0]           colour,
    output logic                  opaque
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MAP,
        S_TILE,
        S_FETCH,
        S_PAL,
        S_DONE
    } state_t;

    // configuration
    logic [1:0] char_block_reg;
    logic [4:0] screen_block_reg;
    logic [1:0] map_size_reg;
    logic       colour_depth_reg;
    logic [8:0] scroll_x_reg;
    logic [8:0] scroll_y_reg;

    // sequencer and output
    state_t              state_reg, state_next;
    logic [VIDEO_AW-1:0] vram_addr_reg, vram_addr_next;
    logic [2:0]          col_reg, col_next;
    logic [2:0]          row_reg, row_next;
    logic [3:0]          bank_reg, bank_next;
    logic                byte_sel_reg, byte_sel_next;
    logic                pal_zero_reg, pal_zero_next;
    logic                out_valid_reg, out_valid_next;
    logic [31:0]         colour_reg, colour_next;
    logic                opaque_reg, opaque_next;

    // memories
    logic [15:0] video_mem [VIDEO_WORDS];
    logic [15:0] palette_mem [PALETTE_ENTRIES];
    logic [15:0] vram_q_reg;
    logic [15:0] pal_q_reg;

    logic       in_accept;
    logic       wide;
    logic       tall;
    logic [8:0] sum_x;
    logic [8:0] sum_y;
    logic [8:0] mx;
    logic [8:0] my;
    logic [1:0] block;
    logic [5:0] sb_sum;
    logic [15:0] map_half;
    logic [15:0] tile_off;
    logic [15:0] tile_half;
    logic [7:0]  tile_byte;
    logic [3:0]  nib;
    logic [PAL_AW-1:0] pal_idx;

    assign cfg_ready = 1'b1;
    assign in_stall  = (state_reg != S_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign colour    = colour_reg;
    assign opaque    = opaque_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            char_block_reg   <= '0;
            screen_block_reg <= '0;
            map_size_reg     <= '0;
            colour_depth_reg <= 1'b0;
            scroll_x_reg     <= '0;
            scroll_y_reg     <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_CHAR_BLOCK:   char_block_reg   <= cfg_data[1:0];
                CFG_SCREEN_BLOCK: screen_block_reg <= cfg_data[4:0];
                CFG_MAP_SIZE:     map_size_reg     <= cfg_data[1:0];
                CFG_COLOUR_DEPTH: colour_depth_reg <= cfg_data[0];
                CFG_SCROLL_X:     scroll_x_reg     <= cfg_data;
                CFG_SCROLL_Y:     scroll_y_reg     <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // map address
    assign wide     = map_size_reg[0];
    assign tall     = map_size_reg[1];
    assign sum_x    = {1'b0, pixel_x} + scroll_x_reg;
    assign sum_y    = {1'b0, pixel_y} + scroll_y_reg;
    assign mx       = wide ? sum_x : {1'b0, sum_x[7:0]};
    assign my       = tall ? sum_y : {1'b0, sum_y[7:0]};
    assign block    = {1'b0, mx[8]} + (wide ? {my[8], 1'b0} : {1'b0, my[8]});
    assign sb_sum   = {1'b0, screen_block_reg} + {4'd0, block};
    assign map_half = {sb_sum, my[7:3], mx[7:3]};

    // tile address, halfword units
    assign tile_off  = colour_depth_reg
                     ? {1'b0, vram_q_reg[9:0], row_reg, col_reg[2:1]}
                     : {2'b0, vram_q_reg[9:0], row_reg, col_reg[2]};
    assign tile_half = {1'b0, char_block_reg, 13'd0} + tile_off;

    // palette index
    assign tile_byte = byte_sel_reg ? vram_q_reg[15:8] : vram_q_reg[7:0];
    assign nib       = col_reg[0] ? tile_byte[7:4] : tile_byte[3:0];
    assign pal_idx   = colour_depth_reg ? tile_byte
                     : ((nib == 4'd0) ? '0 : {bank_reg, nib});

    always_comb
    begin
        state_next     = state_reg;
        vram_addr_next = vram_addr_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        bank_next      = bank_reg;
        byte_sel_next  = byte_sel_reg;
        pal_zero_next  = pal_zero_reg;
        out_valid_next = out_valid_reg && out_stall;
        colour_next    = colour_reg;
        opaque_next    = opaque_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_accept && (opcode == OP_RENDER))
                begin
                    vram_addr_next = map_half[VIDEO_AW-1:0];
                    col_next       = mx[2:0];
                    row_next       = my[2:0];
                    state_next     = S_MAP;
                end
            end
            S_MAP:
            begin
                state_next = S_TILE;
            end
            S_TILE:
            begin
                bank_next      = vram_q_reg[15:12];
                byte_sel_next  = colour_depth_reg ? col_reg[0] : col_reg[1];
                vram_addr_next = tile_half[VIDEO_AW-1:0];
                state_next     = S_FETCH;
            end
            S_FETCH:
            begin
                state_next = S_PAL;
            end
            S_PAL:
            begin
                pal_zero_next = (pal_idx == '0);
                state_next    = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    opaque_next    = !pal_zero_reg;
                    colour_next    = pal_zero_reg ? 32'd0
                                   : {ALPHA_OPAQUE, pal_q_reg[4:0], 3'd0,
                                      pal_q_reg[9:5], 3'd0, pal_q_reg[14:10], 3'd0};
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            vram_addr_reg <= '0;
            col_reg       <= '0;
            row_reg       <= '0;
            bank_reg      <= '0;
            byte_sel_reg  <= 1'b0;
            pal_zero_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            colour_reg    <= '0;
            opaque_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            vram_addr_reg <= vram_addr_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            bank_reg      <= bank_next;
            byte_sel_reg  <= byte_sel_next;
            pal_zero_reg  <= pal_zero_next;
            out_valid_reg <= out_valid_next;
            colour_reg    <= colour_next;
            opaque_reg    <= opaque_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept && (opcode == OP_VRAM_WR))
        begin
            video_mem[VIDEO_AW'(address)] <= write_data;
        end
        vram_q_reg <= video_mem[vram_addr_reg];
    end

    always_ff @(posedge clk)
    begin
        if (in_accept && (opcode == OP_PAL_WR))
        begin
            palette_mem[address[PAL_AW-1:0]] <= write_data;
        end
        if (state_reg == S_PAL)
        begin
            pal_q_reg <= palette_mem[pal_idx];
        end
    end

    `TBPR_ASSERT_NEXT(a_render_starts,
        in_accept && (opcode == OP_RENDER), state_reg == S_MAP,
        "render item did not start the map read")
    `TBPR_ASSERT_NEXT(a_write_one_cycle,
        in_accept && (opcode != OP_RENDER), state_reg == S_IDLE,
        "non-render item left the sequencer busy")
    `TBPR_ASSERT_NEXT(a_done_delivers,
        (state_reg == S_DONE) && (!out_valid_reg || !out_stall), out_valid_reg,
        "finished render item not presented")
    `TBPR_ASSERT_NOW(a_transparent_black,
        out_valid_reg && !opaque_reg, colour_reg == 32'd0,
        "transparent item with nonzero colour")

endmodule
